>>> rtl/gocc_pkg.sv
// gocc_pkg: shared types and constants of the gyro oscillation cycle counter
// holds field widths, register codes and reset values, the direction code,
// and the config, state and result structs; depends on nothing

package gocc_pkg;

	// field and datapath widths
	localparam int RATE_W     = 24;
	localparam int TIME_W     = 32;
	localparam int THR_W      = 23;
	localparam int GAIN_W     = 16;
	localparam int GAP_W      = 16;
	localparam int BIAS_W     = 40;
	localparam int D_W        = 41;
	localparam int FRAC_W     = 16;
	localparam int CNT_W      = 32;
	localparam int FULL_W     = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REST_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_GAIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP_MS     = 3'd4;

	// register reset values
	localparam logic [THR_W-1:0]  RST_REST_THRESHOLD = 23'd3840;
	localparam logic [GAIN_W-1:0] RST_BIAS_GAIN      = 16'd655;
	localparam logic [THR_W-1:0]  RST_DEADBAND       = 23'd3840;
	localparam logic [THR_W-1:0]  RST_PEAK_THRESHOLD = 23'd12800;
	localparam logic [GAP_W-1:0]  RST_MIN_GAP_MS     = 16'd250;

	// saturation limits of the centered output
	localparam logic signed [RATE_W-1:0] RATE_MAX = 24'sh7FFFFF;
	localparam logic signed [RATE_W-1:0] RATE_MIN = 24'sh800000;

	// three-way sign of the centered value
	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_POS  = 2'd1,
		DIR_NEG  = 2'd2
	} dir_t;

	typedef struct packed {
		logic [THR_W-1:0]  rest_threshold;
		logic [GAIN_W-1:0] bias_gain;
		logic [THR_W-1:0]  deadband;
		logic [THR_W-1:0]  peak_threshold;
		logic [GAP_W-1:0]  min_gap_ms;
	} cfg_t;

	typedef struct packed {
		logic                     started;
		logic [TIME_W-1:0]        start_time;
		logic [TIME_W-1:0]        last_cross_elapsed;
		logic signed [BIAS_W-1:0] bias_value;
		dir_t                     last_direction;
		logic                     positive_lobe_seen;
		logic                     negative_lobe_seen;
		logic [CNT_W-1:0]         half_cycles;
	} state_t;

	typedef struct packed {
		logic signed [RATE_W-1:0] centered_rate;
		logic                     crossing_counted;
		logic [CNT_W-1:0]         half_cycle_count;
		logic [FULL_W-1:0]        full_cycle_count;
	} result_t;

endpackage

>>> rtl/gyro_oscillation_cycle_counter_top.sv
// gyro_oscillation_cycle_counter_top: top level of the cycle counter
// input register, state registers and result register around gocc_step;
// uses gocc_pkg, gocc_cfg_regs and gocc_step
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   in      | in_valid / in_stall | rate_sample, time_ms
//   out     | out_valid/out_stall | centered_rate, crossing_counted,
//           |                     | half_cycle_count, full_cycle_count
//   cfg     | cfg_write           | cfg_index, cfg_data
//
// one item per cycle sustained while out_stall stays low; a taken item goes
// into the input register, then through gocc_step into the result register;
// the bias and counter state update as the item moves into the result register
// reset clears the state and control flags and loads the config reset values
// while a result waits on out_stall, one more item is held in the input
// register; in_stall rises only when both registers are full

module gyro_oscillation_cycle_counter_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [gocc_pkg::RATE_W-1:0]      rate_sample,
	input  logic [gocc_pkg::TIME_W-1:0]             time_ms,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [gocc_pkg::RATE_W-1:0]      centered_rate,
	output logic                                    crossing_counted,
	output logic [gocc_pkg::CNT_W-1:0]              half_cycle_count,
	output logic [gocc_pkg::FULL_W-1:0]             full_cycle_count,
	input  logic                                    cfg_write,
	input  logic [gocc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [gocc_pkg::CFG_DATA_W-1:0]         cfg_data
);

	gocc_pkg::cfg_t    cfg;
	gocc_pkg::state_t  state_q;
	gocc_pkg::state_t  state_nxt;
	gocc_pkg::result_t res;
	gocc_pkg::result_t result_s2;

	logic                                valid_s1;
	logic signed [gocc_pkg::RATE_W-1:0]  rate_sample_s1;
	logic [gocc_pkg::TIME_W-1:0]         time_ms_s1;
	logic                                valid_s2;
	logic                                advance;
	logic                                accept_in;

	gocc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gocc_step u_step (
		.cfg         (cfg),
		.cur         (state_q),
		.rate_sample (rate_sample_s1),
		.time_ms     (time_ms_s1),
		.nxt         (state_nxt),
		.res         (res)
	);

	// handshake: result register frees or is empty
	assign advance   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept_in || (valid_s1 && !advance);
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (accept_in) begin
			rate_sample_s1 <= rate_sample;
			time_ms_s1     <= time_ms;
		end
	end

	// filter and counter state, committed as the item moves to the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.started            <= 1'b0;
			state_q.start_time         <= '0;
			state_q.last_cross_elapsed <= '0;
			state_q.bias_value         <= '0;
			state_q.last_direction     <= gocc_pkg::DIR_NONE;
			state_q.positive_lobe_seen <= 1'b0;
			state_q.negative_lobe_seen <= 1'b0;
			state_q.half_cycles        <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1 && advance)
			result_s2 <= res;
	end

	assign out_valid        = valid_s2;
	assign centered_rate    = result_s2.centered_rate;
	assign crossing_counted = result_s2.crossing_counted;
	assign half_cycle_count = result_s2.half_cycle_count;
	assign full_cycle_count = result_s2.full_cycle_count;

endmodule

>>> rtl/gocc_cfg_regs.sv
// gocc_cfg_regs: configuration register file of the cycle counter
// plain write port, masks data to each register width; uses gocc_pkg

module gocc_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [gocc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gocc_pkg::CFG_DATA_W-1:0]      cfg_data,
	output gocc_pkg::cfg_t                       cfg
);

	gocc_pkg::cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rest_threshold <= gocc_pkg::RST_REST_THRESHOLD;
			cfg_q.bias_gain      <= gocc_pkg::RST_BIAS_GAIN;
			cfg_q.deadband       <= gocc_pkg::RST_DEADBAND;
			cfg_q.peak_threshold <= gocc_pkg::RST_PEAK_THRESHOLD;
			cfg_q.min_gap_ms     <= gocc_pkg::RST_MIN_GAP_MS;
		end else if (cfg_write) begin
			case (cfg_index)
				gocc_pkg::REG_REST_THRESHOLD: cfg_q.rest_threshold <= cfg_data;
				gocc_pkg::REG_BIAS_GAIN:
					cfg_q.bias_gain <= cfg_data[gocc_pkg::GAIN_W-1:0];
				gocc_pkg::REG_DEADBAND:       cfg_q.deadband <= cfg_data;
				gocc_pkg::REG_PEAK_THRESHOLD: cfg_q.peak_threshold <= cfg_data;
				gocc_pkg::REG_MIN_GAP_MS:
					cfg_q.min_gap_ms <= cfg_data[gocc_pkg::GAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/gocc_step.sv
// gocc_step: per-item datapath of the cycle counter, purely combinational
// bias filter, lobe and sign detection, crossing count; uses gocc_pkg

module gocc_step (
	input  gocc_pkg::cfg_t                       cfg,
	input  gocc_pkg::state_t                     cur,
	input  logic signed [gocc_pkg::RATE_W-1:0]   rate_sample,
	input  logic [gocc_pkg::TIME_W-1:0]          time_ms,
	output gocc_pkg::state_t                     nxt,
	output gocc_pkg::result_t                    res
);

	localparam int D_W    = gocc_pkg::D_W;
	localparam int FRAC_W = gocc_pkg::FRAC_W;
	localparam int PROD_W = gocc_pkg::GAIN_W + 1 + gocc_pkg::BIAS_W;

	logic signed [D_W-1:0]    x_s;
	logic signed [D_W-1:0]    bias_s;
	logic signed [D_W-1:0]    d_raw;
	logic signed [D_W-1:0]    rest_s;
	logic signed [D_W-1:0]    db_s;
	logic signed [D_W-1:0]    pk_s;
	logic                     at_rest;
	logic signed [PROD_W-1:0] prod;
	logic signed [D_W-1:0]    delta;
	logic signed [D_W-1:0]    bias_sum;
	logic signed [D_W-1:0]    d;
	logic                     pos_seen;
	logic                     neg_seen;
	gocc_pkg::dir_t           dir;
	logic [gocc_pkg::TIME_W-1:0] elapsed;
	logic [gocc_pkg::TIME_W-1:0] gap;
	logic                     change;
	logic                     counted;
	logic signed [gocc_pkg::RATE_W:0] c_wide;

	// sample and thresholds lifted to signed Q25.16
	assign x_s    = $signed({rate_sample[gocc_pkg::RATE_W-1], rate_sample, {FRAC_W{1'b0}}});
	assign bias_s = $signed({cur.bias_value[gocc_pkg::BIAS_W-1], cur.bias_value});
	assign rest_s = $signed({2'b00, cfg.rest_threshold, {FRAC_W{1'b0}}});
	assign db_s   = $signed({2'b00, cfg.deadband, {FRAC_W{1'b0}}});
	assign pk_s   = $signed({2'b00, cfg.peak_threshold, {FRAC_W{1'b0}}});

	assign d_raw   = x_s - bias_s;
	assign at_rest = (d_raw < rest_s) && (d_raw > -rest_s);

	// bias filter step, d fits 40 bits whenever it is applied
	assign prod     = $signed({1'b0, cfg.bias_gain}) *
		$signed(d_raw[gocc_pkg::BIAS_W-1:0]);
	assign delta    = at_rest ? prod[PROD_W-1:FRAC_W] : '0;
	assign bias_sum = bias_s + delta;
	assign d        = d_raw - delta;

	// lobe flags
	assign pos_seen = cur.positive_lobe_seen || (d >= pk_s);
	assign neg_seen = cur.negative_lobe_seen || (d <= -pk_s);

	// sign with deadband
	always_comb begin
		if (d > db_s)
			dir = gocc_pkg::DIR_POS;
		else if (d < -db_s)
			dir = gocc_pkg::DIR_NEG;
		else
			dir = gocc_pkg::DIR_NONE;
	end

	// time since first item and since last counted crossing
	assign elapsed = time_ms - (cur.started ? cur.start_time : time_ms);
	assign gap     = elapsed - cur.last_cross_elapsed;

	assign change  = (dir != gocc_pkg::DIR_NONE) && (dir != cur.last_direction) &&
		(gap >= {{(gocc_pkg::TIME_W-gocc_pkg::GAP_W){1'b0}}, cfg.min_gap_ms});
	assign counted = change && (((dir == gocc_pkg::DIR_POS) && neg_seen) ||
		((dir == gocc_pkg::DIR_NEG) && pos_seen));

	// next state
	always_comb begin
		nxt                    = cur;
		nxt.started            = 1'b1;
		nxt.start_time         = cur.started ? cur.start_time : time_ms;
		nxt.bias_value         = bias_sum[gocc_pkg::BIAS_W-1:0];
		nxt.positive_lobe_seen = pos_seen;
		nxt.negative_lobe_seen = neg_seen;
		if (change)
			nxt.last_direction = dir;
		if (counted) begin
			nxt.half_cycles        = cur.half_cycles + 1'b1;
			nxt.last_cross_elapsed = elapsed;
			if (dir == gocc_pkg::DIR_POS)
				nxt.negative_lobe_seen = 1'b0;
			else
				nxt.positive_lobe_seen = 1'b0;
		end
	end

	// centered output, floor to a 24-bit integer (Q24.0) and saturate
	assign c_wide = d[D_W-1:FRAC_W];

	always_comb begin
		if (c_wide[gocc_pkg::RATE_W] == c_wide[gocc_pkg::RATE_W-1])
			res.centered_rate = c_wide[gocc_pkg::RATE_W-1:0];
		else if (c_wide[gocc_pkg::RATE_W])
			res.centered_rate = gocc_pkg::RATE_MIN;
		else
			res.centered_rate = gocc_pkg::RATE_MAX;
		res.crossing_counted = counted;
		res.half_cycle_count = nxt.half_cycles;
		res.full_cycle_count = nxt.half_cycles[gocc_pkg::CNT_W-1:1];
	end

endmodule

>>> verif/tb_gyro_oscillation_cycle_counter_top.sv
// tb_gyro_oscillation_cycle_counter_top: self-checking testbench of the cycle counter
// drives samples and register writes, predicts bias, sign and counts per item
// and checks every result; depends on gocc_pkg and gyro_oscillation_cycle_counter_top
`timescale 1ns / 100ps

module tb_gyro_oscillation_cycle_counter_top;

	localparam int     RATE_W           = gocc_pkg::RATE_W;
	localparam int     THR_W            = gocc_pkg::THR_W;
	localparam int     GAIN_W           = gocc_pkg::GAIN_W;
	localparam int     GAP_W            = gocc_pkg::GAP_W;
	localparam int     DATA_W           = gocc_pkg::CFG_DATA_W;
	localparam int     JUNK_W           = gocc_pkg::CFG_DATA_W - gocc_pkg::GAIN_W;
	localparam longint FRAC_ONE         = 64'sd65536;
	localparam int     LONG_HOLD_CYCLES = 80;
	localparam int     RUN_LIMIT_NS     = 6_000_000;
	localparam gocc_pkg::cfg_t CFG_DEFAULTS = '{gocc_pkg::RST_REST_THRESHOLD,
		gocc_pkg::RST_BIAS_GAIN, gocc_pkg::RST_DEADBAND, gocc_pkg::RST_PEAK_THRESHOLD,
		gocc_pkg::RST_MIN_GAP_MS};

	logic                                   clk;
	logic                                   arst_n;
	logic                                   in_valid;
	logic                                   in_stall;
	logic signed [gocc_pkg::RATE_W-1:0]     rate_sample;
	logic [gocc_pkg::TIME_W-1:0]            time_ms;
	logic                                   out_valid;
	logic                                   out_stall;
	logic signed [gocc_pkg::RATE_W-1:0]     centered_rate;
	logic                                   crossing_counted;
	logic [gocc_pkg::CNT_W-1:0]             half_cycle_count;
	logic [gocc_pkg::FULL_W-1:0]            full_cycle_count;
	logic                                   cfg_write;
	logic [gocc_pkg::CFG_IDX_W-1:0]         cfg_index;
	logic [gocc_pkg::CFG_DATA_W-1:0]        cfg_data;

	gyro_oscillation_cycle_counter_top dut (.*);

	// predicted settings and counter state
	gocc_pkg::cfg_t              cf;
	bit                          seen_first;
	logic [gocc_pkg::TIME_W-1:0] t_origin;
	logic [gocc_pkg::TIME_W-1:0] t_last_count;
	longint                      bias_acc;
	gocc_pkg::dir_t              prev_dir;
	bit                          lobe_pos;
	bit                          lobe_neg;
	logic [gocc_pkg::CNT_W-1:0]  half_count;

	gocc_pkg::result_t           results_due[$];
	int                          fail_count = 0;
	int                          samples_sent = 0;
	logic [gocc_pkg::TIME_W-1:0] wave_clock;
	bit                          sender_idles = 1'b1;
	bit                          receiver_idles = 1'b1;
	bit                          hold_request = 1'b0;
	bit                          hold_active = 1'b0;

	initial begin : clock_gen
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

	function automatic void reset_model();
		cf           = CFG_DEFAULTS;
		seen_first   = 1'b0;
		t_origin     = '0;
		t_last_count = '0;
		bias_acc     = 0;
		prev_dir     = gocc_pkg::DIR_NONE;
		lobe_pos     = 1'b0;
		lobe_neg     = 1'b0;
		half_count   = '0;
	endfunction

	// extra bits are dropped, unknown indexes leave everything as it was
	function automatic void apply_register(input logic [gocc_pkg::CFG_IDX_W-1:0] idx,
			input logic [gocc_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			gocc_pkg::REG_REST_THRESHOLD: cf.rest_threshold = data[THR_W-1:0];
			gocc_pkg::REG_BIAS_GAIN:      cf.bias_gain      = data[GAIN_W-1:0];
			gocc_pkg::REG_DEADBAND:       cf.deadband       = data[THR_W-1:0];
			gocc_pkg::REG_PEAK_THRESHOLD: cf.peak_threshold = data[THR_W-1:0];
			gocc_pkg::REG_MIN_GAP_MS:     cf.min_gap_ms     = data[GAP_W-1:0];
			default: ;
		endcase
	endfunction

	// one sample through bias tracking, deadband sign and crossing count
	function automatic gocc_pkg::result_t track_sample(
			input logic signed [gocc_pkg::RATE_W-1:0] rate,
			input logic [gocc_pkg::TIME_W-1:0] now);
		longint                      x, d, rest_lim, db_lim, pk_lim, c;
		logic [gocc_pkg::TIME_W-1:0] elapsed, since_count;
		gocc_pkg::dir_t              dir;
		gocc_pkg::result_t           r;
		x = longint'(rate);
		if (!seen_first) begin
			seen_first = 1'b1;
			t_origin   = now;
		end
		elapsed  = now - t_origin;
		rest_lim = longint'(cf.rest_threshold) * FRAC_ONE;
		db_lim   = longint'(cf.deadband) * FRAC_ONE;
		pk_lim   = longint'(cf.peak_threshold) * FRAC_ONE;

		// bias follows the input only near rest
		d = x * FRAC_ONE - bias_acc;
		if (d < rest_lim && d > -rest_lim) begin
			bias_acc += (longint'(cf.bias_gain) * d) >>> gocc_pkg::FRAC_W;
			d = x * FRAC_ONE - bias_acc;
		end

		if (d >= pk_lim)
			lobe_pos = 1'b1;
		if (d <= -pk_lim)
			lobe_neg = 1'b1;

		if (d > db_lim)
			dir = gocc_pkg::DIR_POS;
		else if (d < -db_lim)
			dir = gocc_pkg::DIR_NEG;
		else
			dir = gocc_pkg::DIR_NONE;

		// side change outside the refractory window; counted only after the opposite peak
		since_count = elapsed - t_last_count;
		r.crossing_counted = 1'b0;
		if (dir != gocc_pkg::DIR_NONE && dir != prev_dir &&
				since_count >= cf.min_gap_ms) begin
			if ((dir == gocc_pkg::DIR_POS && lobe_neg) ||
					(dir == gocc_pkg::DIR_NEG && lobe_pos)) begin
				half_count++;
				t_last_count = elapsed;
				if (dir == gocc_pkg::DIR_POS)
					lobe_neg = 1'b0;
				else
					lobe_pos = 1'b0;
				r.crossing_counted = 1'b1;
			end
			prev_dir = dir;
		end

		// output saturates, compares above used the full value
		c = d >>> gocc_pkg::FRAC_W;
		if (c > longint'(gocc_pkg::RATE_MAX))
			c = longint'(gocc_pkg::RATE_MAX);
		if (c < longint'(gocc_pkg::RATE_MIN))
			c = longint'(gocc_pkg::RATE_MIN);
		r.centered_rate    = c[RATE_W-1:0];
		r.half_cycle_count = half_count;
		r.full_cycle_count = half_count[gocc_pkg::CNT_W-1:1];
		return r;
	endfunction

	// result check against the oldest prediction
	always @(posedge clk) begin : result_check
		gocc_pkg::result_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				$error("result with none expected: centered_rate %0d", centered_rate);
				fail_count++;
			end else begin
				due = results_due.pop_front();
				if (centered_rate !== due.centered_rate) begin
					$error("centered_rate: expected %0d, got %0d", due.centered_rate,
						centered_rate);
					fail_count++;
				end
				if (crossing_counted !== due.crossing_counted) begin
					$error("crossing_counted: expected %0d, got %0d", due.crossing_counted,
						crossing_counted);
					fail_count++;
				end
				if (half_cycle_count !== due.half_cycle_count) begin
					$error("half_cycle_count: expected %0d, got %0d", due.half_cycle_count,
						half_cycle_count);
					fail_count++;
				end
				if (full_cycle_count !== due.full_cycle_count) begin
					$error("full_cycle_count: expected %0d, got %0d", due.full_cycle_count,
						full_cycle_count);
					fail_count++;
				end
			end
		end
	end

	// receiver: bursts of stalls, quiet stretches, and a long hold on request
	initial begin : receiver
		int pass_len, stall_len;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				hold_active  = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_active  = 1'b0;
			end else if (!receiver_idles || $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end else begin
				pass_len  = $urandom_range(0, 5);
				stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
				if (pass_len > 0) begin
					out_stall <= 1'b0;
					repeat (pass_len) @(posedge clk);
				end
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	function automatic int sender_gap();
		int pick;
		if (!sender_idles)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one item, predict its result once taken
	task automatic send_sample(input logic signed [gocc_pkg::RATE_W-1:0] rate,
			input logic [gocc_pkg::TIME_W-1:0] now);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		rate_sample <= rate;
		time_ms     <= now;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		results_due.push_back(track_sample(rate, now));
		samples_sent++;
	endtask

	// stop offering and let every pending result come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// caller lowers cfg_write after the last write of a group
	task automatic write_register(input logic [gocc_pkg::CFG_IDX_W-1:0] idx,
			input logic [gocc_pkg::CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		apply_register(idx, data);
	endtask

	// all five registers, narrow ones with junk in the unused upper bits
	task automatic program_registers(input gocc_pkg::cfg_t v);
		logic [JUNK_W-1:0] junk;
		write_register(gocc_pkg::REG_REST_THRESHOLD, v.rest_threshold);
		junk = JUNK_W'($urandom);
		write_register(gocc_pkg::REG_BIAS_GAIN, {junk, v.bias_gain});
		write_register(gocc_pkg::REG_DEADBAND, v.deadband);
		write_register(gocc_pkg::REG_PEAK_THRESHOLD, v.peak_threshold);
		junk = JUNK_W'($urandom);
		write_register(gocc_pkg::REG_MIN_GAP_MS, {junk, v.min_gap_ms});
		cfg_write <= 1'b0;
	endtask

	function automatic logic [gocc_pkg::THR_W-1:0] pick_level();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return THR_W'($urandom);
			default: return THR_W'($urandom_range(0, 20000));
		endcase
	endfunction

	function automatic gocc_pkg::cfg_t random_settings();
		gocc_pkg::cfg_t r;
		r.rest_threshold = pick_level();
		r.deadband       = pick_level();
		r.peak_threshold = pick_level();
		case ($urandom_range(0, 5))
			0: r.bias_gain = '0;
			1: r.bias_gain = '1;
			2: r.bias_gain = gocc_pkg::RST_BIAS_GAIN;
			default: r.bias_gain = GAIN_W'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: r.min_gap_ms = '0;
			1: r.min_gap_ms = '1;
			default: r.min_gap_ms = GAP_W'($urandom_range(0, 400));
		endcase
		return r;
	endfunction

	// triangle oscillation around a small offset, sized against the peak level
	task automatic send_wave(input int n);
		longint amp, offset, noise_span, v, pk;
		int     period, half, ph, step_ms, k;
		pk = longint'(cf.peak_threshold);
		case ($urandom_range(0, 5))
			0: amp = pk / 2;
			1: amp = $urandom_range(0, 8388607);
			default: amp = pk + pk / 4 + $urandom_range(0, 4000);
		endcase
		offset     = longint'($urandom_range(0, 4000)) - 2000;
		noise_span = longint'(cf.deadband) / 4 + 64;
		if (noise_span > 100000)
			noise_span = 100000;
		period  = $urandom_range(8, 60);
		half    = period / 2;
		ph      = $urandom_range(0, period - 1);
		step_ms = $urandom_range(2, 20);
		for (k = 0; k < n; k++) begin
			if (ph < half)
				v = -amp + (2 * amp * ph) / half;
			else
				v = amp - (2 * amp * (ph - half)) / (period - half);
			v += offset + longint'($urandom_range(0, 2 * noise_span)) - noise_span;
			if (v > longint'(gocc_pkg::RATE_MAX))
				v = longint'(gocc_pkg::RATE_MAX);
			if (v < longint'(gocc_pkg::RATE_MIN))
				v = longint'(gocc_pkg::RATE_MIN);
			send_sample(v[RATE_W-1:0], wave_clock);
			wave_clock += step_ms;
			if ($urandom_range(0, 15) == 0)
				wave_clock += $urandom_range(0, 100);
			ph = (ph + 1) % period;
		end
	endtask

	// full-range samples, random or backwards timestamps
	task automatic send_noise(input int n);
		repeat (n) begin
			if ($urandom_range(0, 1))
				send_sample(RATE_W'($urandom), $urandom);
			else
				send_sample(RATE_W'($urandom), wave_clock - $urandom_range(0, 500));
		end
	endtask

	// first sample sets the time origin: no count inside the first gap
	task automatic test_first_sample_gap();
		wave_clock = 32'd1000;
		send_sample(24'sd0, wave_clock);
		send_sample(24'sd20000, wave_clock + 10);
		send_sample(-24'sd20000, wave_clock + 20);
		send_sample(24'sd20000, wave_clock + 300);
		send_sample(-24'sd20000, wave_clock + 600);
		wave_clock += 700;
	endtask

	task automatic test_field_extremes();
		send_sample(gocc_pkg::RATE_MAX, 32'hFFFF_FFFF);
		send_sample(gocc_pkg::RATE_MIN, 32'h0000_0000);
		send_sample(-24'sd1, 32'h8000_0000);
		send_sample(24'sd1, 32'h7FFF_FFFF);
	endtask

	// every register, masking of narrow ones, writes to unused indexes
	task automatic test_register_access();
		logic [gocc_pkg::CFG_IDX_W-1:0] idx;
		drain_results();
		write_register(gocc_pkg::REG_REST_THRESHOLD, 23'd6000);
		write_register(gocc_pkg::REG_BIAS_GAIN, {7'h55, 16'd40000});
		write_register(gocc_pkg::REG_DEADBAND, 23'd2000);
		write_register(gocc_pkg::REG_PEAK_THRESHOLD, 23'd9000);
		write_register(gocc_pkg::REG_MIN_GAP_MS, {7'h2A, 16'd120});
		cfg_write <= 1'b0;
		send_sample(24'sd9500, wave_clock);
		send_sample(-24'sd9500, wave_clock + 130);
		drain_results();
		// indexes past the last register, stops when idx wraps to zero
		for (idx = gocc_pkg::REG_MIN_GAP_MS + 1'b1; idx != 0; idx++)
			write_register(idx, DATA_W'($urandom));
		cfg_write <= 1'b0;
		send_sample(24'sd9500, wave_clock + 300);
		wave_clock += 400;
	endtask

	// drag the bias to each end, then jump across for saturated outputs
	task automatic test_centered_saturation();
		gocc_pkg::cfg_t v;
		drain_results();
		v = CFG_DEFAULTS;
		v.rest_threshold = '1;
		v.bias_gain      = '1;
		program_registers(v);
		send_sample(24'sd8000000, wave_clock);
		send_sample(gocc_pkg::RATE_MIN, wave_clock + 10);
		send_sample(24'sd0, wave_clock + 20);
		send_sample(-24'sd8000000, wave_clock + 30);
		send_sample(gocc_pkg::RATE_MAX, wave_clock + 40);
		send_sample(24'sd0, wave_clock + 50);
		wave_clock += 60;
	endtask

	// timestamps wrap through zero, then one goes backwards
	task automatic test_timestamp_wrap();
		gocc_pkg::cfg_t v;
		int             k;
		drain_results();
		v = CFG_DEFAULTS;
		v.min_gap_ms = 16'd100;
		program_registers(v);
		for (k = 0; k < 8; k++)
			send_sample((k % 2) ? -24'sd30000 : 24'sd30000, 32'hFFFF_FF00 + k * 60);
		send_sample(24'sd30000, 32'hFFFF_FE00);
		wave_clock = 32'h0000_0300;
	endtask

	// receiver holds off while items keep coming, so the block fills up
	task automatic test_full_backpressure();
		drain_results();
		sender_idles = 1'b0;
		hold_request = 1'b1;
		while (!hold_active)
			@(posedge clk);
		send_wave(24);
		sender_idles = 1'b1;
	endtask

	// phases of settings, mostly clean oscillation with some noise mixed in
	task automatic test_random_oscillation();
		int             target, phase, phase_end;
		gocc_pkg::cfg_t v;
		target = samples_sent + 1600;
		phase  = 0;
		while (samples_sent < target) begin
			drain_results();
			case (phase)
				0: v = '1;
				1: v = '0;
				2: v = CFG_DEFAULTS;
				default: v = random_settings();
			endcase
			program_registers(v);
			sender_idles   = (phase % 3 != 1);
			receiver_idles = (phase % 4 != 2);
			if ($urandom_range(0, 5) == 0)
				wave_clock = 32'hFFFF_F000 + $urandom_range(0, 2048);
			phase_end = samples_sent + 100;
			while (samples_sent < phase_end) begin
				if ($urandom_range(0, 4) != 0)
					send_wave($urandom_range(20, 80));
				else
					send_noise($urandom_range(1, 8));
			end
			phase++;
		end
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
	endtask

	initial begin : sequencer
		in_valid    <= 1'b0;
		rate_sample <= '0;
		time_ms     <= '0;
		cfg_write   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		arst_n      <= 1'b0;
		reset_model();
		wave_clock = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_sample_gap();
		test_field_extremes();
		test_register_access();
		test_centered_saturation();
		test_timestamp_wrap();
		test_full_backpressure();
		test_random_oscillation();

		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
